[sv/eamr_pkg.sv]
// Shared constants for the Euler angle to rotation matrix pipeline.
// No dependencies; imported by every module of the block except eamr_cdiv.
`timescale 1ns / 1ps
package eamr_pkg;

  // Default number of fraction bits of the sine, cosine and matrix entries.
  localparam int FRAC_BITS_DEF = 14;

  // Angle format: signed, 1/64 degree units.
  localparam int ANGLE_W     = 16;
  localparam int RED_W       = 15;
  localparam int RR_W        = 12;
  localparam int FULL_TURN   = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int EIGHTH_TURN = 2880;

  // Q30 series arithmetic, held in 31 bits so that 1.0 fits.
  localparam int            Q30_W = 31;
  localparam logic [30:0]   ONE30 = 31'h4000_0000;

  // Pi in Q48; radians = r * PI48 / (45 * 2^26) in Q30, split into
  // a whole quotient and a remainder for two narrow products.
  localparam logic [63:0] PI48    = 64'h0003_243F_6A88_85A3;
  localparam logic [63:0] OCT_DIV = 64'd45 << 26;
  localparam logic [63:0] PI_Q    = PI48 / OCT_DIV;
  localparam logic [63:0] PI_R    = PI48 % OCT_DIV;

  // Pipeline depth.
  localparam int SC_STAGES   = 15;
  localparam int MM_STAGES   = 2;
  localparam int PIPE_STAGES = SC_STAGES + 2 * MM_STAGES;

endpackage

[sv/euler_angles_to_rotation_matrix_core.sv]
// Euler ZYX rotation matrix core: R = Rz * Ry * Rx from three angles.
// The pipeline has 19 register stages.
// Throughput: one angle triple per cycle; a stall holds only the full stages
// behind the output, while empty stages still fill.
// Reset clears all valid bits and sets handedness to right-handed.
// Depends on eamr_pkg, eamr_pipe_ctrl, eamr_sincos and eamr_matmul.
`timescale 1ns / 1ps
module euler_angles_to_rotation_matrix_core #(
  parameter int FRAC_BITS = eamr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [eamr_pkg::ANGLE_W-1:0] in_angle_x,
  input  logic signed [eamr_pkg::ANGLE_W-1:0] in_angle_y,
  input  logic signed [eamr_pkg::ANGLE_W-1:0] in_angle_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [FRAC_BITS+1:0]         out_r00,
  output logic signed [FRAC_BITS+1:0]         out_r01,
  output logic signed [FRAC_BITS+1:0]         out_r02,
  output logic signed [FRAC_BITS+1:0]         out_r10,
  output logic signed [FRAC_BITS+1:0]         out_r11,
  output logic signed [FRAC_BITS+1:0]         out_r12,
  output logic signed [FRAC_BITS+1:0]         out_r20,
  output logic signed [FRAC_BITS+1:0]         out_r21,
  output logic signed [FRAC_BITS+1:0]         out_r22
);
  import eamr_pkg::*;

  localparam int W = FRAC_BITS + 2;
  localparam logic signed [W-1:0] ONE  = W'(1) <<< FRAC_BITS;
  localparam logic signed [W-1:0] ZERO = '0;
  localparam int M1 = SC_STAGES;
  localparam int M2 = SC_STAGES + MM_STAGES;

  logic                   hand_r;
  logic [PIPE_STAGES-1:0] ld;
  logic signed [W-1:0]    sx, cx, sy, cy, sz, cz;
  logic signed [W-1:0]    sx_r [2];
  logic signed [W-1:0]    cx_r [2];
  logic signed [W-1:0]    rz [3][3];
  logic signed [W-1:0]    ry [3][3];
  logic signed [W-1:0]    rx [3][3];
  logic signed [W-1:0]    t  [3][3];
  logic signed [W-1:0]    r  [3][3];

  // Handedness register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hand_r <= 1'b0;
    end else if (cfg_we) begin
      hand_r <= cfg_wdata;
    end
  end

  eamr_pipe_ctrl #(.STAGES(PIPE_STAGES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .ld
  );

  // One sine and cosine pipeline for each axis.
  eamr_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_x (
    .clk, .ld(ld[SC_STAGES-1:0]), .angle(in_angle_x), .neg(hand_r), .sin_o(sx), .cos_o(cx)
  );
  eamr_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_y (
    .clk, .ld(ld[SC_STAGES-1:0]), .angle(in_angle_y), .neg(hand_r), .sin_o(sy), .cos_o(cy)
  );
  eamr_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_z (
    .clk, .ld(ld[SC_STAGES-1:0]), .angle(in_angle_z), .neg(hand_r), .sin_o(sz), .cos_o(cz)
  );

  // The x terms wait alongside the first product.
  always_ff @(posedge clk) begin
    if (ld[M1]) begin
      sx_r[0] <= sx;
      cx_r[0] <= cx;
    end
    if (ld[M1+1]) begin
      sx_r[1] <= sx_r[0];
      cx_r[1] <= cx_r[0];
    end
  end

  // Elementary rotations.
  assign rz = '{'{cz, sz, ZERO}, '{-sz, cz, ZERO}, '{ZERO, ZERO, ONE}};
  assign ry = '{'{cy, ZERO, -sy}, '{ZERO, ONE, ZERO}, '{sy, ZERO, cy}};
  assign rx = '{'{ONE, ZERO, ZERO}, '{ZERO, cx_r[1], sx_r[1]},
                '{ZERO, -sx_r[1], cx_r[1]}};

  eamr_matmul #(.FRAC_BITS(FRAC_BITS)) u_mm_zy (
    .clk, .ld(ld[M1+MM_STAGES-1:M1]), .a(rz), .b(ry), .o(t)
  );
  eamr_matmul #(.FRAC_BITS(FRAC_BITS)) u_mm_x (
    .clk, .ld(ld[M2+MM_STAGES-1:M2]), .a(t), .b(rx), .o(r)
  );

  assign out_r00 = r[0][0];
  assign out_r01 = r[0][1];
  assign out_r02 = r[0][2];
  assign out_r10 = r[1][0];
  assign out_r11 = r[1][1];
  assign out_r12 = r[1][2];
  assign out_r20 = r[2][0];
  assign out_r21 = r[2][1];
  assign out_r22 = r[2][2];

endmodule

[sv/eamr_cdiv.sv]
// Division of an unsigned value by a constant, by reciprocal multiplication.
// Depends on nothing; used by the sine and cosine pipeline.
`timescale 1ns / 1ps
module eamr_cdiv #(
  parameter int DIVISOR = 3,
  parameter int IN_W    = 31
) (
  input  logic [IN_W-1:0] num,
  output logic [IN_W-1:0] quo
);
  // With K = IN_W + clog2(DIVISOR) the rounded-up reciprocal is exact
  // for every numerator below 2^IN_W.
  localparam int K = IN_W + $clog2(DIVISOR);
  localparam logic [IN_W+1:0] M = (IN_W+2)'(((64'd1 << K) / DIVISOR) + 64'd1);

  logic [2*IN_W+1:0] prod;

  assign prod = {{(IN_W+2){1'b0}}, num} * {{IN_W{1'b0}}, M};
  assign quo  = IN_W'(prod >> K);

endmodule

[sv/eamr_sincos.sv]
// Pipelined sine and cosine of one angle: range reduction, octant series
// in Q30 and rounding. Depends on eamr_pkg and eamr_cdiv.
`timescale 1ns / 1ps
module eamr_sincos #(
  parameter int FRAC_BITS = eamr_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic [eamr_pkg::SC_STAGES-1:0]       ld,
  input  logic signed [eamr_pkg::ANGLE_W-1:0]  angle,
  input  logic                                 neg,
  output logic signed [FRAC_BITS+1:0]          sin_o,
  output logic signed [FRAC_BITS+1:0]          cos_o
);
  import eamr_pkg::*;

  localparam int W  = FRAC_BITS + 2;
  localparam int MW = FRAC_BITS + 1;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [17:0] FT  = 18'(FULL_TURN);
  localparam logic signed [17:0] FT2 = 18'(2 * FULL_TURN);

  function automatic logic [Q30_W-1:0] mul30(input logic [Q30_W-1:0] a,
                                             input logic [Q30_W-1:0] b);
    logic [2*Q30_W-1:0] p;
    p = {{Q30_W{1'b0}}, a} * {{Q30_W{1'b0}}, b};
    return p[30 +: Q30_W];
  endfunction

  // Control carried along with the data: quadrant and octant swap.
  logic [1:0]        q_r   [2:SC_STAGES-1];
  logic              sw_r  [2:SC_STAGES-1];
  logic [RED_W-1:0]  red_r;
  logic [RR_W-1:0]   rr_r;
  logic [30:0]       p1_r;
  logic [43:0]       a_r;
  logic [Q30_W-1:0]  x_r   [4:12];
  logic [Q30_W-1:0]  x2_r  [5:12];
  logic [Q30_W-1:0]  ts_r  [0:3];
  logic [Q30_W-1:0]  tc_r  [0:3];
  logic [Q30_W-1:0]  ps_r  [0:2];
  logic [Q30_W-1:0]  pc_r  [0:3];
  logic [Q30_W-1:0]  s30_r;
  logic [MW-1:0]     sm_r;
  logic [MW-1:0]     cm_r;
  logic signed [W-1:0] sin_r;
  logic signed [W-1:0] cos_r;

  logic signed [17:0] a_ext;
  logic signed [17:0] red_s;
  logic [1:0]         q_nxt;
  logic [12:0]        r_nxt;
  logic [RR_W-1:0]    rr_nxt;
  logic               sw_nxt;
  logic [17:0]        f45;
  logic [Q30_W-1:0]   d72, d90, d42, d56, d20, d30, d6, d12;
  logic [Q30_W-1:0]   c30;
  logic [MW-1:0]      sm_nxt, cm_nxt;
  logic signed [W-1:0] sp, cp, sin_nxt, cos_nxt;

  // Stage 1: wrap the angle into one turn.
  always_comb begin
    a_ext = 18'(angle);
    if (a_ext < -FT) begin
      red_s = a_ext + FT2;
    end else if (a_ext < 18'sd0) begin
      red_s = a_ext + FT;
    end else if (a_ext >= FT) begin
      red_s = a_ext - FT;
    end else begin
      red_s = a_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      red_r <= red_s[RED_W-1:0];
    end
  end

  // Stage 2: quadrant, remainder and fold into the first octant.
  always_comb begin
    if (red_r >= RED_W'(3 * QUARTER_TURN)) begin
      q_nxt = 2'd3;
      r_nxt = 13'(red_r - RED_W'(3 * QUARTER_TURN));
    end else if (red_r >= RED_W'(2 * QUARTER_TURN)) begin
      q_nxt = 2'd2;
      r_nxt = 13'(red_r - RED_W'(2 * QUARTER_TURN));
    end else if (red_r >= RED_W'(QUARTER_TURN)) begin
      q_nxt = 2'd1;
      r_nxt = 13'(red_r - RED_W'(QUARTER_TURN));
    end else begin
      q_nxt = 2'd0;
      r_nxt = 13'(red_r);
    end
    sw_nxt = (r_nxt > 13'(EIGHTH_TURN));
    rr_nxt = sw_nxt ? RR_W'(13'(QUARTER_TURN) - r_nxt) : RR_W'(r_nxt);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      q_r[2]  <= q_nxt;
      sw_r[2] <= sw_nxt;
      rr_r    <= rr_nxt;
    end
  end

  // Quadrant and swap ride along beside the rounded magnitudes.
  for (genvar g = 3; g < SC_STAGES; g++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (ld[g-1]) begin
        q_r[g]  <= q_r[g-1];
        sw_r[g] <= sw_r[g-1];
      end
    end
  end

  // Stage 3: octant angle to radians, two partial products.
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      p1_r <= 31'({19'd0, rr_r} * PI_Q[30:0]);
      a_r  <= 44'({32'd0, rr_r} * PI_R[31:0]);
    end
  end

  // Stage 4: x in Q30 radians.
  eamr_cdiv #(.DIVISOR(45), .IN_W(18)) u_div45 (.num(a_r[43:26]), .quo(f45));

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      x_r[4] <= Q30_W'(p1_r) + Q30_W'(f45);
    end
  end

  // Stage 5: x squared.
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      x_r[5]  <= x_r[4];
      x2_r[5] <= mul30(x_r[4], x_r[4]);
    end
  end

  for (genvar g = 6; g <= 12; g++) begin : g_carry
    always_ff @(posedge clk) begin
      if (ld[g-1]) begin
        x_r[g]  <= x_r[g-1];
        x2_r[g] <= x2_r[g-1];
      end
    end
  end

  // Horner steps of both series, divide stage then multiply stage.
  eamr_cdiv #(.DIVISOR(72), .IN_W(Q30_W)) u_d72 (.num(x2_r[5]),  .quo(d72));
  eamr_cdiv #(.DIVISOR(90), .IN_W(Q30_W)) u_d90 (.num(x2_r[5]),  .quo(d90));
  eamr_cdiv #(.DIVISOR(42), .IN_W(Q30_W)) u_d42 (.num(ps_r[0]),  .quo(d42));
  eamr_cdiv #(.DIVISOR(56), .IN_W(Q30_W)) u_d56 (.num(pc_r[0]),  .quo(d56));
  eamr_cdiv #(.DIVISOR(20), .IN_W(Q30_W)) u_d20 (.num(ps_r[1]),  .quo(d20));
  eamr_cdiv #(.DIVISOR(30), .IN_W(Q30_W)) u_d30 (.num(pc_r[1]),  .quo(d30));
  eamr_cdiv #(.DIVISOR(6),  .IN_W(Q30_W)) u_d6  (.num(ps_r[2]),  .quo(d6));
  eamr_cdiv #(.DIVISOR(12), .IN_W(Q30_W)) u_d12 (.num(pc_r[2]),  .quo(d12));

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      ts_r[0] <= ONE30 - d72;
      tc_r[0] <= ONE30 - d90;
    end
    if (ld[6]) begin
      ps_r[0] <= mul30(x2_r[6], ts_r[0]);
      pc_r[0] <= mul30(x2_r[6], tc_r[0]);
    end
    if (ld[7]) begin
      ts_r[1] <= ONE30 - d42;
      tc_r[1] <= ONE30 - d56;
    end
    if (ld[8]) begin
      ps_r[1] <= mul30(x2_r[8], ts_r[1]);
      pc_r[1] <= mul30(x2_r[8], tc_r[1]);
    end
    if (ld[9]) begin
      ts_r[2] <= ONE30 - d20;
      tc_r[2] <= ONE30 - d30;
    end
    if (ld[10]) begin
      ps_r[2] <= mul30(x2_r[10], ts_r[2]);
      pc_r[2] <= mul30(x2_r[10], tc_r[2]);
    end
    if (ld[11]) begin
      ts_r[3] <= ONE30 - d6;
      tc_r[3] <= ONE30 - d12;
    end
    // Stage 13: last products of the series.
    if (ld[12]) begin
      s30_r   <= mul30(x_r[12], ts_r[3]);
      pc_r[3] <= mul30(x2_r[12], tc_r[3]);
    end
  end

  // Stage 14: finish the cosine and round both magnitudes.
  assign c30 = ONE30 - {1'b0, pc_r[3][Q30_W-1:1]};

  if (SH == 0) begin : g_noround
    assign sm_nxt = MW'(s30_r);
    assign cm_nxt = MW'(c30);
  end else begin : g_round
    logic [Q30_W:0] s_add, c_add;
    assign s_add  = {1'b0, s30_r} + (32'd1 << (SH - 1));
    assign c_add  = {1'b0, c30} + (32'd1 << (SH - 1));
    assign sm_nxt = MW'(s_add >> SH);
    assign cm_nxt = MW'(c_add >> SH);
  end

  always_ff @(posedge clk) begin
    if (ld[13]) begin
      sm_r <= sm_nxt;
      cm_r <= cm_nxt;
    end
  end

  // Stage 15: undo the octant fold, apply quadrant signs and handedness.
  always_comb begin
    sp = sw_r[SC_STAGES-1] ? $signed({1'b0, cm_r}) : $signed({1'b0, sm_r});
    cp = sw_r[SC_STAGES-1] ? $signed({1'b0, sm_r}) : $signed({1'b0, cm_r});
    case (q_r[SC_STAGES-1])
      2'd0: begin
        sin_nxt = sp;
        cos_nxt = cp;
      end
      2'd1: begin
        sin_nxt = cp;
        cos_nxt = -sp;
      end
      2'd2: begin
        sin_nxt = -sp;
        cos_nxt = -cp;
      end
      default: begin
        sin_nxt = -cp;
        cos_nxt = sp;
      end
    endcase
    if (neg) begin
      sin_nxt = -sin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[14]) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

[sv/eamr_matmul.sv]
// Two-stage 3x3 fixed-point matrix product: rounded products, then
// saturated sums. Depends on eamr_pkg.
`timescale 1ns / 1ps
module eamr_matmul #(
  parameter int FRAC_BITS = eamr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [eamr_pkg::MM_STAGES-1:0] ld,
  input  logic signed [FRAC_BITS+1:0] a [3][3],
  input  logic signed [FRAC_BITS+1:0] b [3][3],
  output logic signed [FRAC_BITS+1:0] o [3][3]
);
  import eamr_pkg::*;

  localparam int W = FRAC_BITS + 2;
  localparam logic signed [W+1:0] ONE_S = (W+2)'(1) <<< FRAC_BITS;

  logic signed [W-1:0] prod_r [3][3][3];
  logic signed [W-1:0] prod_nxt [3][3][3];
  logic signed [W-1:0] o_r [3][3];
  logic signed [W-1:0] o_nxt [3][3];

  // Products rounded on the magnitude, half away from zero.
  always_comb begin
    logic [W-1:0]   ua, ub;
    logic [2*W-1:0] pw;
    logic [W-1:0]   pm;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          ua = a[i][k][W-1] ? W'(-a[i][k]) : W'(a[i][k]);
          ub = b[k][j][W-1] ? W'(-b[k][j]) : W'(b[k][j]);
          pw = ({{W{1'b0}}, ua} * {{W{1'b0}}, ub}) + ((2*W)'(1) << (FRAC_BITS - 1));
          pm = W'(pw >> FRAC_BITS);
          prod_nxt[i][j][k] = (a[i][k][W-1] != b[k][j][W-1]) ? -$signed(pm) : $signed(pm);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      prod_r <= prod_nxt;
    end
  end

  // Sums saturated to plus or minus one.
  always_comb begin
    logic signed [W+1:0] acc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = (W+2)'(prod_r[i][j][0]) + (W+2)'(prod_r[i][j][1]) + (W+2)'(prod_r[i][j][2]);
        if (acc > ONE_S) begin
          o_nxt[i][j] = W'(ONE_S);
        end else if (acc < -ONE_S) begin
          o_nxt[i][j] = W'(-ONE_S);
        end else begin
          o_nxt[i][j] = W'(acc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      o_r <= o_nxt;
    end
  end

  assign o = o_r;

endmodule

[sv/eamr_pipe_ctrl.sv]
// Valid bits and per-stage load enables of the pipeline; a stage takes new
// data when it is empty or its successor moves on. Depends on eamr_pkg.
`timescale 1ns / 1ps
module eamr_pipe_ctrl #(
  parameter int STAGES = eamr_pkg::PIPE_STAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAGES-1:0] ld
);
  import eamr_pkg::*;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] v_nxt;

  // Load enables ripple back from the output side.
  always_comb begin
    ld[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
    v_nxt = v_r;
    for (int i = 0; i < STAGES; i++) begin
      if (ld[i]) begin
        v_nxt[i] = (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[STAGES-1];

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STAGES-1] && !out_ready |=> v_r[STAGES-1])
    else $error("result lost while stalled");
  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_ready)
    else $error("input blocked although the pipeline has a free stage");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted transfer did not enter the first stage");
`endif

endmodule
